### sv/refcounted_inode_cache_table_defines.svh
// Assertion helpers shared by the RTL. Each macro expects clk and arst_n in scope.
`ifndef REFCOUNTED_INODE_CACHE_TABLE_DEFINES_SVH
`define REFCOUNTED_INODE_CACHE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RICT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RICT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/rict_pkg.sv
`default_nettype none

package rict_pkg;

	localparam int KEY_W = 16;
	localparam int CNT_W = 16;
	localparam int EIDX_W = 6;

	typedef logic [1:0] cmd_t;
	typedef logic [2:0] status_t;

	localparam cmd_t CMD_GET  = 2'd0;
	localparam cmd_t CMD_DUP  = 2'd1;
	localparam cmd_t CMD_PUT  = 2'd2;
	localparam cmd_t CMD_NONE = 2'd3;

	localparam status_t ST_HIT         = 3'd0;
	localparam status_t ST_CLAIMED     = 3'd1;
	localparam status_t ST_FULL        = 3'd2;
	localparam status_t ST_NOT_IN_USE  = 3'd3;
	localparam status_t ST_OVERFLOW    = 3'd4;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// Request as it travels down the row of cells.
	typedef struct packed {
		cmd_t              command;
		logic [KEY_W-1:0]  device;
		logic [KEY_W-1:0]  inode_number;
		logic [EIDX_W-1:0] entry_index;
	} req_t;

	// Partial search result gathered along the row.
	typedef struct packed {
		logic             hit;
		logic             free;
		logic [CNT_W-1:0] refs;
	} scan_t;

	// Update broadcast to the row once the search is complete.
	typedef struct packed {
		logic             we;
		logic             key_we;
		logic [CNT_W-1:0] refs;
		logic [KEY_W-1:0] device;
		logic [KEY_W-1:0] inode_number;
	} commit_t;

endpackage

`default_nettype wire

### sv/rict_cell.sv
`default_nettype none

// One table entry plus one stage of the search chain.
module rict_cell #(
	parameter int IDX_W    = 6,
	parameter int CELL_IDX = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  v_in,
	input  wire rict_pkg::req_t  req_in,
	input  wire rict_pkg::scan_t scan_in,
	input  wire [IDX_W-1:0]      hit_idx_in,
	input  wire [IDX_W-1:0]      free_idx_in,
	output logic                 v_out,
	output rict_pkg::req_t       req_out,
	output rict_pkg::scan_t      scan_out,
	output logic [IDX_W-1:0]     hit_idx_out,
	output logic [IDX_W-1:0]     free_idx_out,
	input  wire rict_pkg::commit_t commit,
	input  wire [IDX_W-1:0]      commit_idx
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [rict_pkg::KEY_W-1:0] dev_q;
	logic [rict_pkg::KEY_W-1:0] ino_q;
	logic [rict_pkg::CNT_W-1:0] refs_q;

	logic            v_s1;
	rict_pkg::req_t  req_s1;
	rict_pkg::scan_t scan_s1;
	logic [IDX_W-1:0] hit_idx_s1;
	logic [IDX_W-1:0] free_idx_s1;

	logic own_hit;
	logic own_free;
	logic sel;

	assign sel = commit.we && (commit_idx == MY_IDX);

	// A get matches on key in a live entry; dup and put match on position.
	always_comb begin
		own_hit  = 1'b0;
		own_free = 1'b0;
		case (req_in.command)
			rict_pkg::CMD_GET: begin
				own_hit  = (refs_q != '0) && (dev_q == req_in.device) &&
					(ino_q == req_in.inode_number);
				own_free = (refs_q == '0);
			end
			rict_pkg::CMD_DUP, rict_pkg::CMD_PUT: begin
				own_hit = (32'(req_in.entry_index) == 32'(CELL_IDX));
			end
			default: begin
				own_hit  = 1'b0;
				own_free = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refs_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			v_s1 <= v_in;
			if (sel) begin
				refs_q <= commit.refs;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && commit.key_we) begin
			dev_q <= commit.device;
			ino_q <= commit.inode_number;
		end
		req_s1       <= req_in;
		scan_s1.hit  <= scan_in.hit | own_hit;
		scan_s1.free <= scan_in.free | own_free;
		if (!scan_in.hit && own_hit) begin
			hit_idx_s1   <= MY_IDX;
			scan_s1.refs <= refs_q;
		end else begin
			hit_idx_s1   <= hit_idx_in;
			scan_s1.refs <= scan_in.refs;
		end
		if (!scan_in.free && own_free) begin
			free_idx_s1 <= MY_IDX;
		end else begin
			free_idx_s1 <= free_idx_in;
		end
	end

	assign v_out        = v_s1;
	assign req_out      = req_s1;
	assign scan_out     = scan_s1;
	assign hit_idx_out  = hit_idx_s1;
	assign free_idx_out = free_idx_s1;

endmodule

`default_nettype wire

### sv/refcounted_inode_cache_table.sv
// Reference-counted object cache table.
// Requests enter on the req channel (req_valid / req_stall) and carry a command, a
// device/inode key and an entry index. Each accepted get, dup or put request yields
// exactly one response on the rsp channel (rsp_valid / rsp_stall); a request with
// the unused command code is absorbed and gives no response.
// One request is processed at a time. It walks the row of TABLE_ENTRIES cells, one
// cell per cycle, its result is then registered in the holding register, and the
// next request is taken once that result has moved on into the output register.
// A finished response sits in a holding register and then in the output register,
// so a new request may be accepted while the receiver still stalls the previous
// response; only a second completed response waits for the output to drain.
// Reset clears every reference count at once, so the table starts empty and a
// request may be sent in the first cycle after reset is released.
// A stalled response holds its value until the receiver takes it.

`default_nettype none
`include "refcounted_inode_cache_table_defines.svh"

module refcounted_inode_cache_table #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           req_valid,
	output logic                          req_stall,
	input  wire [1:0]                     command,
	input  wire [15:0]                    device,
	input  wire [15:0]                    inode_number,
	input  wire [5:0]                     entry_index,
	output logic                          rsp_valid,
	input  wire                           rsp_stall,
	output logic [5:0]                    result_index,
	output logic [2:0]                    status,
	output logic                          last_reference,
	output logic [15:0]                   ref_count
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	// Control states: waiting for a request, search in flight, response pending.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q;

	// Chain links; link 0 is fed from the request port, the last one is the exit.
	logic              v_c        [0:TABLE_ENTRIES];
	rict_pkg::req_t    req_c      [0:TABLE_ENTRIES];
	rict_pkg::scan_t   scan_c     [0:TABLE_ENTRIES];
	logic [IDX_W-1:0]  hit_idx_c  [0:TABLE_ENTRIES];
	logic [IDX_W-1:0]  free_idx_c [0:TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] busy_vec;

	rict_pkg::commit_t commit;
	logic [IDX_W-1:0]  commit_idx;

	logic                                 accept;
	logic                                 x_v;
	rict_pkg::req_t                       x_req;
	rict_pkg::scan_t                      x_scan;
	logic [rict_pkg::EIDX_W-1:0]          r_idx;
	rict_pkg::status_t                    r_st;
	logic                                 r_last;
	logic [rict_pkg::CNT_W-1:0]           r_cnt;
	logic [rict_pkg::CNT_W-1:0]           cnt_inc;
	logic [rict_pkg::CNT_W-1:0]           cnt_dec;
	logic                                 upd;

	logic [rict_pkg::EIDX_W-1:0]          pend_idx_q;
	rict_pkg::status_t                    pend_st_q;
	logic                                 pend_last_q;
	logic [rict_pkg::CNT_W-1:0]           pend_cnt_q;

	logic                                 rsp_valid_q;
	logic [rict_pkg::EIDX_W-1:0]          rsp_idx_q;
	rict_pkg::status_t                    rsp_st_q;
	logic                                 rsp_last_q;
	logic [rict_pkg::CNT_W-1:0]           rsp_cnt_q;
	logic                                 rsp_load;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	// Requests with the unused command code never enter the chain.
	assign v_c[0]                = accept && (command != rict_pkg::CMD_NONE);
	assign req_c[0].command      = command;
	assign req_c[0].device       = device;
	assign req_c[0].inode_number = inode_number;
	assign req_c[0].entry_index  = entry_index;
	assign scan_c[0]             = '0;
	assign hit_idx_c[0]          = '0;
	assign free_idx_c[0]         = '0;

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		rict_cell #(
			.IDX_W   (IDX_W),
			.CELL_IDX(g)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.v_in        (v_c[g]),
			.req_in      (req_c[g]),
			.scan_in     (scan_c[g]),
			.hit_idx_in  (hit_idx_c[g]),
			.free_idx_in (free_idx_c[g]),
			.v_out       (v_c[g+1]),
			.req_out     (req_c[g+1]),
			.scan_out    (scan_c[g+1]),
			.hit_idx_out (hit_idx_c[g+1]),
			.free_idx_out(free_idx_c[g+1]),
			.commit      (commit),
			.commit_idx  (commit_idx)
		);
		assign busy_vec[g] = v_c[g+1];
	end

	assign x_v    = v_c[TABLE_ENTRIES];
	assign x_req  = req_c[TABLE_ENTRIES];
	assign x_scan = scan_c[TABLE_ENTRIES];

	assign cnt_inc = x_scan.refs + 16'd1;
	assign cnt_dec = x_scan.refs - 16'd1;

	// Decide the outcome once the request leaves the last cell. The entry update is
	// broadcast in the same cycle, while the chain is otherwise empty.
	always_comb begin
		r_idx  = rict_pkg::EIDX_W'(hit_idx_c[TABLE_ENTRIES]);
		r_st   = rict_pkg::ST_HIT;
		r_last = 1'b0;
		r_cnt  = cnt_inc;
		upd    = 1'b0;
		commit_idx          = hit_idx_c[TABLE_ENTRIES];
		commit.key_we       = 1'b0;
		commit.refs         = cnt_inc;
		commit.device       = x_req.device;
		commit.inode_number = x_req.inode_number;
		case (x_req.command)
			rict_pkg::CMD_GET: begin
				if (x_scan.hit) begin
					if (x_scan.refs == rict_pkg::COUNT_MAX) begin
						r_st  = rict_pkg::ST_OVERFLOW;
						r_cnt = rict_pkg::COUNT_MAX;
					end else begin
						upd = 1'b1;
					end
				end else if (x_scan.free) begin
					upd           = 1'b1;
					commit.key_we = 1'b1;
					commit.refs   = 16'd1;
					commit_idx    = free_idx_c[TABLE_ENTRIES];
					r_idx         = rict_pkg::EIDX_W'(free_idx_c[TABLE_ENTRIES]);
					r_st          = rict_pkg::ST_CLAIMED;
					r_cnt         = 16'd1;
				end else begin
					r_idx = '0;
					r_st  = rict_pkg::ST_FULL;
					r_cnt = '0;
				end
			end
			rict_pkg::CMD_DUP, rict_pkg::CMD_PUT: begin
				if (!x_scan.hit || (x_scan.refs == '0)) begin
					r_idx = x_req.entry_index;
					r_st  = rict_pkg::ST_NOT_IN_USE;
					r_cnt = '0;
				end else if (x_req.command == rict_pkg::CMD_DUP) begin
					if (x_scan.refs == rict_pkg::COUNT_MAX) begin
						r_st  = rict_pkg::ST_OVERFLOW;
						r_cnt = rict_pkg::COUNT_MAX;
					end else begin
						upd = 1'b1;
					end
				end else begin
					upd         = 1'b1;
					commit.refs = cnt_dec;
					r_cnt       = cnt_dec;
					r_last      = (cnt_dec == '0);
				end
			end
			default: begin
				upd = 1'b0;
			end
		endcase
		commit.we = x_v && upd;
	end

	// The output register may be refilled in the same cycle that it drains.
	assign rsp_load = (state_q == ST_HOLD) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (v_c[0]) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (x_v) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (x_v) begin
			pend_idx_q  <= r_idx;
			pend_st_q   <= r_st;
			pend_last_q <= r_last;
			pend_cnt_q  <= r_cnt;
		end
		if (rsp_load) begin
			rsp_idx_q  <= pend_idx_q;
			rsp_st_q   <= pend_st_q;
			rsp_last_q <= pend_last_q;
			rsp_cnt_q  <= pend_cnt_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign result_index   = rsp_idx_q;
	assign status         = rsp_st_q;
	assign last_reference = rsp_last_q;
	assign ref_count      = rsp_cnt_q;

	`RICT_ASSERT_IMP(a_one_in_flight, 1'b1, $countones(busy_vec) <= 1,
		"more than one request in the search chain")
	`RICT_ASSERT_IMP(a_chain_in_scan, |busy_vec, state_q == ST_SCAN,
		"search chain busy outside the scan state")
	`RICT_ASSERT_NXT(a_enter_scan, v_c[0], state_q == ST_SCAN && busy_vec[0],
		"accepted request did not enter the search chain")
	`RICT_ASSERT_IMP(a_claim_count, x_v && commit.key_we,
		commit.we && commit.refs == 16'd1, "key written without a claim of count one")

endmodule

`default_nettype wire

### tb/sv/tb_refcounted_inode_cache_table.sv
`timescale 1ns / 1ps

module tb_refcounted_inode_cache_table;

	typedef logic [rict_pkg::KEY_W-1:0]  key_t;
	typedef logic [rict_pkg::EIDX_W-1:0] eidx_t;
	typedef logic [rict_pkg::CNT_W-1:0]  cnt_t;

	// The table size must match the block's parameter, since the shadow table below
	// mirrors every entry.
	localparam int ENTRIES = 64;

	// Number of cycles without any handshake on either channel before the run is
	// declared hung. The limit is several times the longest quiet stretch of a healthy
	// run: one request walking the whole row while the sender idles and the receiver
	// stalls for their longest draws, or the final settling wait after the last reply.
	localparam int WATCHDOG_CYCLES = 2000;

	// Size of the pool of keys that random gets draw from, so that hits are common.
	localparam int KEY_POOL = 16;

	// Key that the count overflow test drives to the largest count. It stays in the
	// key pool afterward, so random gets on it keep running into the overflow status.
	localparam key_t SATURATED_DEV = 16'h7E57;
	localparam key_t SATURATED_INO = 16'h0F10;

	// One response as it leaves the block.
	typedef struct packed {
		eidx_t             index;
		rict_pkg::status_t status;
		logic              last;
		cnt_t              count;
	} cache_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// All inputs of the block start at known values.
	logic           req_valid = 1'b0;
	rict_pkg::cmd_t command = rict_pkg::CMD_GET;
	key_t           device = '0;
	key_t           inode_number = '0;
	eidx_t          entry_index = '0;
	logic           rsp_stall = 1'b0;

	logic              req_stall;
	logic              rsp_valid;
	eidx_t             result_index;
	rict_pkg::status_t status;
	logic              last_reference;
	cnt_t              ref_count;

	refcounted_inode_cache_table #(
		.TABLE_ENTRIES(ENTRIES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.command(command),
		.device(device),
		.inode_number(inode_number),
		.entry_index(entry_index),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.result_index(result_index),
		.status(status),
		.last_reference(last_reference),
		.ref_count(ref_count)
	);

	// Shadow copy of the table: the key and the reference count of every entry.
	key_t shadow_dev [ENTRIES];
	key_t shadow_ino [ENTRIES];
	cnt_t shadow_refs [ENTRIES];

	// Replies that accepted requests are still owed, oldest first.
	cache_reply_t pending_replies[$];

	key_t pool_dev [KEY_POOL];
	key_t pool_ino [KEY_POOL];

	// When set, neither side idles: the sender has no gaps and the receiver never stalls.
	bit quiet = 1'b0;

	int failures = 0;
	int replies_checked = 0;
	int requests_sent = 0;
	int ignored_sent = 0;
	int status_tally [5];
	int idle_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Any handshake on either channel counts as progress. A long stretch without
	// progress means the block has hung, and the run ends right there.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("Watchdog: no request or response moved for %0d cycles.", idle_cycles);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Failures are always counted, but only the first ten are described.
	function automatic void note_failure(input string what);
		if (failures < 10) begin
			$display("[%0t] %s", $realtime, what);
		end
		failures++;
	endfunction

	// Works out the reply to one accepted request and updates the shadow table the
	// way the block updates its own. A request with the unused command code changes
	// nothing and is owed no reply.
	function automatic void predict_cache_reply(input rict_pkg::cmd_t c, input key_t d,
		input key_t n, input eidx_t idx);
		cache_reply_t r;
		int hit_at;
		int free_at;
		r = '0;
		hit_at = -1;
		free_at = -1;
		case (c)
		rict_pkg::CMD_GET: begin
			// Keys only count in entries that are in use; the claim goes to the
			// lowest-numbered free entry.
			for (int e = 0; e < ENTRIES; e++) begin
				if (hit_at < 0 && shadow_refs[e] != 0 && shadow_dev[e] == d
					&& shadow_ino[e] == n) begin
					hit_at = e;
				end
				if (free_at < 0 && shadow_refs[e] == 0) begin
					free_at = e;
				end
			end
			if (hit_at >= 0) begin
				r.index = eidx_t'(hit_at);
				if (shadow_refs[hit_at] == rict_pkg::COUNT_MAX) begin
					r.status = rict_pkg::ST_OVERFLOW;
					r.count = rict_pkg::COUNT_MAX;
				end else begin
					shadow_refs[hit_at]++;
					r.status = rict_pkg::ST_HIT;
					r.count = shadow_refs[hit_at];
				end
			end else if (free_at >= 0) begin
				shadow_dev[free_at] = d;
				shadow_ino[free_at] = n;
				shadow_refs[free_at] = 16'd1;
				r.index = eidx_t'(free_at);
				r.status = rict_pkg::ST_CLAIMED;
				r.count = 16'd1;
			end else begin
				r.status = rict_pkg::ST_FULL;
			end
		end
		rict_pkg::CMD_DUP, rict_pkg::CMD_PUT: begin
			r.index = idx;
			if (shadow_refs[idx] == 0) begin
				r.status = rict_pkg::ST_NOT_IN_USE;
			end else if (c == rict_pkg::CMD_DUP) begin
				if (shadow_refs[idx] == rict_pkg::COUNT_MAX) begin
					r.status = rict_pkg::ST_OVERFLOW;
					r.count = rict_pkg::COUNT_MAX;
				end else begin
					shadow_refs[idx]++;
					r.status = rict_pkg::ST_HIT;
					r.count = shadow_refs[idx];
				end
			end else begin
				shadow_refs[idx]--;
				r.status = rict_pkg::ST_HIT;
				r.count = shadow_refs[idx];
				r.last = (shadow_refs[idx] == 0);
			end
		end
		default: begin
			return;
		end
		endcase
		status_tally[r.status]++;
		pending_replies.push_back(r);
	endfunction

	// Response side. The stall for the next reply is drawn when a reply is taken and
	// only runs down while a reply is actually waiting, so every stall lands on a
	// reply rather than being spent while the block is still searching.
	always @(posedge clk or negedge arst_n) begin : reply_side
		int stall_left;
		int draw;
		cache_reply_t got;
		cache_reply_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
		end else if (rsp_valid && !rsp_stall) begin
			got = {result_index, status, last_reference, ref_count};
			replies_checked++;
			if (pending_replies.size() == 0) begin
				note_failure($sformatf({"Reply with no request waiting: index %0d",
					" status %0d last %0d count %0d"},
					got.index, got.status, got.last, got.count));
			end else begin
				want = pending_replies.pop_front();
				if (got.index !== want.index || got.status !== want.status
					|| got.last !== want.last || got.count !== want.count) begin
					note_failure($sformatf({"Reply %0d wrong: expected index %0d status %0d last %0d",
						" count %0d, got index %0d status %0d last %0d count %0d"},
						replies_checked, want.index, want.status, want.last, want.count,
						got.index, got.status, got.last, got.count));
				end
			end
			draw = quiet ? 0 : $urandom_range(0, 19);
			stall_left = draw;
			rsp_stall <= (draw != 0);
		end else if (rsp_valid && stall_left != 0) begin
			stall_left = stall_left - 1;
			rsp_stall <= (stall_left != 0);
		end
	end

	// Sends one request. The task is entered right after a rising edge and returns
	// right after the edge at which the request was taken, leaving valid high so
	// that a following request with no gap goes out back to back.
	task automatic send_request(input rict_pkg::cmd_t c, input key_t d,
		input key_t n, input eidx_t idx);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		command <= c;
		device <= d;
		inode_number <= n;
		entry_index <= idx;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_cache_reply(c, d, n, idx);
		if (c == rict_pkg::CMD_NONE) begin
			ignored_sent++;
		end else begin
			requests_sent++;
		end
	endtask

	// Holds the sender back until every reply owed so far has come out.
	task automatic wait_for_replies();
		req_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	// Picks an entry that is in use most of the time, and any entry now and then.
	function automatic eidx_t pick_entry();
		eidx_t in_use[$];
		for (int e = 0; e < ENTRIES; e++) begin
			if (shadow_refs[e] != 0) begin
				in_use.push_back(eidx_t'(e));
			end
		end
		if (in_use.size() == 0 || $urandom_range(0, 9) == 0) begin
			return eidx_t'($urandom_range(0, ENTRIES - 1));
		end
		return in_use[$urandom_range(0, in_use.size() - 1)];
	endfunction

	// Every command on an empty table: claims with the extreme keys, a hit, dup and
	// put on entries that are and are not in use, the last reference, the unused
	// command code, and reuse of the lowest free entry. The table ends empty.
	task automatic test_basic_commands();
		send_request(rict_pkg::CMD_GET, 16'h0000, 16'h0000, 6'd0);
		send_request(rict_pkg::CMD_GET, 16'hFFFF, 16'hFFFF, 6'd63);
		send_request(rict_pkg::CMD_GET, 16'h0000, 16'hFFFF, 6'd0);
		send_request(rict_pkg::CMD_GET, 16'h0000, 16'h0000, 6'd63);
		send_request(rict_pkg::CMD_DUP, 16'hFFFF, 16'h0000, 6'd0);
		send_request(rict_pkg::CMD_DUP, 16'h0000, 16'h0000, 6'd63);
		send_request(rict_pkg::CMD_PUT, 16'hFFFF, 16'hFFFF, 6'd62);
		send_request(rict_pkg::CMD_PUT, 16'h0000, 16'h0000, 6'd1);
		send_request(rict_pkg::CMD_PUT, 16'h0000, 16'h0000, 6'd1);
		send_request(rict_pkg::CMD_DUP, 16'h0000, 16'h0000, 6'd1);
		// The unused command code must be swallowed without a reply.
		send_request(rict_pkg::CMD_NONE, 16'hFFFF, 16'hFFFF, 6'd63);
		send_request(rict_pkg::CMD_GET, 16'hFFFF, 16'h0000, 6'd0);
		repeat (3) send_request(rict_pkg::CMD_PUT, 16'h0000, 16'h0000, 6'd0);
		send_request(rict_pkg::CMD_PUT, 16'h0000, 16'h0000, 6'd2);
		send_request(rict_pkg::CMD_PUT, 16'h0000, 16'h0000, 6'd1);
		wait_for_replies();
	endtask

	// Fills every entry with a distinct key, then checks that a new key finds the
	// table full while a known key still hits. Freeing one entry lets the next new
	// key claim exactly that entry. Everything is released at the end.
	task automatic test_full_table();
		for (int e = 0; e < ENTRIES; e++) begin
			send_request(rict_pkg::CMD_GET, key_t'(16'hC000 | e), key_t'(16'h3000 | e),
				eidx_t'($urandom_range(0, ENTRIES - 1)));
		end
		send_request(rict_pkg::CMD_GET, 16'h1234, 16'h5678, 6'd0);
		send_request(rict_pkg::CMD_GET, 16'hC005, 16'h3005, 6'd0);
		send_request(rict_pkg::CMD_GET, 16'h1234, 16'h5678, 6'd63);
		send_request(rict_pkg::CMD_PUT, 16'h0000, 16'h0000, 6'd37);
		send_request(rict_pkg::CMD_GET, 16'h1234, 16'h5678, 6'd0);
		send_request(rict_pkg::CMD_GET, 16'hABCD, 16'hDCBA, 6'd0);
		for (int e = 0; e < ENTRIES; e++) begin
			while (shadow_refs[e] != 0) begin
				send_request(rict_pkg::CMD_PUT, key_t'($urandom_range(0, 65535)),
					key_t'($urandom_range(0, 65535)), eidx_t'(e));
			end
		end
		wait_for_replies();
	endtask

	// Drives one entry's count all the way up to its largest value with no idling on
	// either side, since this takes one request per step. Both dup and get must then
	// report the overflow without touching the count. The entry is left at the top so
	// the random traffic keeps meeting it.
	task automatic test_count_overflow();
		eidx_t slot;
		quiet = 1'b1;
		send_request(rict_pkg::CMD_GET, SATURATED_DEV, SATURATED_INO, 6'd0);
		slot = pending_replies[pending_replies.size() - 1].index;
		while (shadow_refs[slot] != rict_pkg::COUNT_MAX) begin
			send_request(rict_pkg::CMD_DUP, 16'h0000, 16'h0000, slot);
		end
		send_request(rict_pkg::CMD_DUP, 16'hFFFF, 16'hFFFF, slot);
		send_request(rict_pkg::CMD_GET, SATURATED_DEV, SATURATED_INO, 6'd0);
		send_request(rict_pkg::CMD_PUT, 16'h0000, 16'h0000, slot);
		send_request(rict_pkg::CMD_DUP, 16'h0000, 16'h0000, slot);
		quiet = 1'b0;
		wait_for_replies();
	endtask

	// Random traffic in phases. Growing phases are mostly gets, many of them on new
	// keys, so the table tends to fill up. Shrinking phases are mostly puts that
	// release entries again. Gets also draw from a small key pool so that hits are
	// frequent. Some phases run with no idling at all on either side.
	task automatic test_random_traffic(input int total);
		int sent;
		int phase_left;
		int roll;
		int get_limit;
		int dup_limit;
		bit growing;
		int pick;
		key_t d;
		key_t n;
		eidx_t idx;
		sent = 0;
		phase_left = 0;
		growing = 1'b0;
		for (int k = 0; k < KEY_POOL; k++) begin
			pool_dev[k] = key_t'($urandom_range(0, 65535));
			pool_ino[k] = key_t'($urandom_range(0, 65535));
		end
		pool_dev[0] = SATURATED_DEV;
		pool_ino[0] = SATURATED_INO;
		pool_dev[1] = 16'h0000;
		pool_ino[1] = 16'h0000;
		pool_dev[2] = 16'hFFFF;
		pool_ino[2] = 16'hFFFF;
		while (sent < total) begin
			if (phase_left == 0) begin
				growing = ~growing;
				phase_left = $urandom_range(40, 120);
				quiet = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 19) == 0) begin
				pick = $urandom_range(3, KEY_POOL - 1);
				pool_dev[pick] = key_t'($urandom_range(0, 65535));
				pool_ino[pick] = key_t'($urandom_range(0, 65535));
			end
			get_limit = growing ? 70 : 15;
			dup_limit = growing ? 85 : 25;
			roll = $urandom_range(0, 99);
			idx = pick_entry();
			d = key_t'($urandom_range(0, 65535));
			n = key_t'($urandom_range(0, 65535));
			if (roll < 2) begin
				// The unused command code is noise and does not count toward the total.
				send_request(rict_pkg::CMD_NONE, d, n, idx);
			end else begin
				if (roll < get_limit) begin
					if ($urandom_range(0, 2) == 0 || !growing) begin
						pick = $urandom_range(0, KEY_POOL - 1);
						d = pool_dev[pick];
						n = pool_ino[pick];
					end
					send_request(rict_pkg::CMD_GET, d, n,
						eidx_t'($urandom_range(0, ENTRIES - 1)));
				end else if (roll < dup_limit) begin
					send_request(rict_pkg::CMD_DUP, d, n, idx);
				end else begin
					send_request(rict_pkg::CMD_PUT, d, n, idx);
				end
				sent++;
				phase_left--;
				// Halfway through, let the block drain completely once.
				if (sent == total / 2) begin
					wait_for_replies();
				end
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		for (int e = 0; e < ENTRIES; e++) begin
			shadow_dev[e] = '0;
			shadow_ino[e] = '0;
			shadow_refs[e] = '0;
		end
		for (int s = 0; s < 5; s++) begin
			status_tally[s] = 0;
		end
		// Reset is held from the start of the run and released at a rising edge; it is never
		// asserted again.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_commands();
		test_full_table();
		test_count_overflow();
		test_random_traffic(1200);

		// Wait for the last replies, then give the block time to show any reply that
		// it should not produce, such as one for an ignored request.
		wait_for_replies();
		repeat (4 * ENTRIES) @(posedge clk);
		if (pending_replies.size() != 0) begin
			note_failure($sformatf("%0d replies never arrived", pending_replies.size()));
		end

		$display("Sent %0d requests plus %0d with the unused command; %0d replies checked.",
			requests_sent, ignored_sent, replies_checked);
		$display("Statuses: hit %0d, claimed %0d, full %0d, not in use %0d, overflow %0d.",
			status_tally[rict_pkg::ST_HIT], status_tally[rict_pkg::ST_CLAIMED],
			status_tally[rict_pkg::ST_FULL], status_tally[rict_pkg::ST_NOT_IN_USE],
			status_tally[rict_pkg::ST_OVERFLOW]);
		if (failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d failures in total.", failures);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/rict_pkg.sv
sv/rict_cell.sv
sv/refcounted_inode_cache_table.sv
tb/sv/tb_refcounted_inode_cache_table.sv
